/* design/see_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// see_pkg: shared types and constants for the stack expression evaluator
// Widths, character codes, status codes and the ALU request type.
// ----------------------------------------------------------------------------
package see_pkg;

	localparam int SEE_STACK_DEPTH = 64;
	localparam int SEE_WORD_W      = 32;
	localparam int SEE_SYM_W       = 8;
	localparam int SEE_STATUS_W    = 3;
	localparam int SEE_DEPTH_W     = 7;

	localparam logic [SEE_SYM_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [SEE_SYM_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [SEE_SYM_W-1:0] CH_MUL   = 8'h2A;
	localparam logic [SEE_SYM_W-1:0] CH_DIV   = 8'h2F;
	localparam logic [SEE_SYM_W-1:0] CH_MOD   = 8'h25;
	localparam logic [SEE_SYM_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [SEE_SYM_W-1:0] CH_NINE  = 8'h39;

	typedef enum logic [SEE_STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_UNDER = 3'd1,
		ST_OVER  = 3'd2,
		ST_DIVZ  = 3'd3,
		ST_BAD   = 3'd4,
		ST_EMPTY = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV,
		ALU_REM
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	function automatic logic is_digit(input logic [SEE_SYM_W-1:0] sym);
		return sym inside {[CH_ZERO:CH_NINE]};
	endfunction

	function automatic logic is_oper(input logic [SEE_SYM_W-1:0] sym);
		return sym inside {CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_MOD};
	endfunction

	function automatic alu_op_t op_of(input logic [SEE_SYM_W-1:0] sym);
		alu_op_t op;
		case (sym)
			CH_PLUS:  op = ALU_ADD;
			CH_MINUS: op = ALU_SUB;
			CH_MUL:   op = ALU_MUL;
			CH_DIV:   op = ALU_DIV;
			CH_MOD:   op = ALU_REM;
			default:  op = ALU_ADD;
		endcase
		return op;
	endfunction

endpackage
`default_nettype wire

/* design/see_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// see_if: valid/ready channels of the stack expression evaluator
// Symbol input, result output and mode configuration channels.
// ----------------------------------------------------------------------------
interface see_sym_if import see_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [SEE_SYM_W-1:0] symbol;
	logic                 last_symbol;

	modport source (output valid, output symbol, output last_symbol, input ready);
	modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface see_res_if import see_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic signed [SEE_WORD_W-1:0]  value;
	logic [SEE_STATUS_W-1:0]       status;
	logic [SEE_DEPTH_W-1:0]        leftover_depth;

	modport source (output valid, output value, output status, output leftover_depth,
		input ready);
	modport sink   (input valid, input value, input status, input leftover_depth,
		output ready);
endinterface

interface see_cfg_if;
	logic valid;
	logic ready;
	logic notation_mode;

	modport source (output valid, output notation_mode, input ready);
	modport sink   (input valid, input notation_mode, output ready);
endinterface
`default_nettype wire

/* design/see_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// see_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module see_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* design/see_alu.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// see_alu: iterative 32-bit arithmetic unit
// One shared adder does add/sub in one pass, multiply by shift-add and
// signed divide/remainder by restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module see_alu import see_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire alu_req_t              req,
	input  wire logic [SEE_WORD_W-1:0] lhs,
	input  wire logic [SEE_WORD_W-1:0] rhs,
	output logic                       done,
	output logic      [SEE_WORD_W-1:0] result
);

	localparam int CNT_W = $clog2(SEE_WORD_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SEE_WORD_W - 1);

	typedef enum logic [2:0] {A_IDLE, A_MUL, A_DIV, A_FIX, A_DONE} a_state_t;

	a_state_t              state_q;
	logic [SEE_WORD_W-1:0] acc_q;   // product / remainder / result
	logic [SEE_WORD_W-1:0] opa_q;   // multiplicand / dividend, then quotient
	logic [SEE_WORD_W-1:0] opb_q;   // multiplier / divisor
	logic [CNT_W-1:0]      cnt_q;
	logic                  neg_q;
	logic                  want_rem_q;

	logic [SEE_WORD_W-1:0] add_x, add_y;
	logic                  add_sub;
	logic [SEE_WORD_W:0]   sum;
	logic [SEE_WORD_W-1:0] rem_sh;
	logic [SEE_WORD_W-1:0] lhs_mag, rhs_mag;

	assign rem_sh  = {acc_q[SEE_WORD_W-2:0], opa_q[SEE_WORD_W-1]};
	assign lhs_mag = lhs[SEE_WORD_W-1] ? (SEE_WORD_W'(0) - lhs) : lhs;
	assign rhs_mag = rhs[SEE_WORD_W-1] ? (SEE_WORD_W'(0) - rhs) : rhs;

	// shared adder operand select
	always_comb begin
		case (state_q)
			A_IDLE: begin
				add_x   = lhs;
				add_y   = rhs;
				add_sub = (req.op == ALU_SUB);
			end
			A_MUL: begin
				add_x   = acc_q;
				add_y   = opa_q;
				add_sub = 1'b0;
			end
			A_DIV: begin
				add_x   = rem_sh;
				add_y   = opb_q;
				add_sub = 1'b1;
			end
			A_FIX: begin
				add_x   = '0;
				add_y   = want_rem_q ? acc_q : opa_q;
				add_sub = 1'b1;
			end
			default: begin
				add_x   = acc_q;
				add_y   = '0;
				add_sub = 1'b0;
			end
		endcase
	end

	assign sum = {1'b0, add_x} + {1'b0, add_sub ? ~add_y : add_y}
		+ (SEE_WORD_W + 1)'(add_sub);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= A_IDLE;
			acc_q      <= '0;
			opa_q      <= '0;
			opb_q      <= '0;
			cnt_q      <= '0;
			neg_q      <= 1'b0;
			want_rem_q <= 1'b0;
		end else begin
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						cnt_q <= '0;
						case (req.op)
							ALU_ADD, ALU_SUB: begin
								acc_q   <= sum[SEE_WORD_W-1:0];
								state_q <= A_DONE;
							end
							ALU_MUL: begin
								acc_q   <= '0;
								opa_q   <= lhs;
								opb_q   <= rhs;
								state_q <= A_MUL;
							end
							ALU_DIV, ALU_REM: begin
								acc_q      <= '0;
								opa_q      <= lhs_mag;
								opb_q      <= rhs_mag;
								want_rem_q <= (req.op == ALU_REM);
								// remainder takes the dividend's sign
								neg_q      <= (req.op == ALU_REM) ? lhs[SEE_WORD_W-1]
									: (lhs[SEE_WORD_W-1] ^ rhs[SEE_WORD_W-1]);
								state_q    <= A_DIV;
							end
							default: begin
								state_q <= A_DONE;
							end
						endcase
					end
				end
				A_MUL: begin
					if (opb_q[0]) begin
						acc_q <= sum[SEE_WORD_W-1:0];
					end
					opa_q <= {opa_q[SEE_WORD_W-2:0], 1'b0};
					opb_q <= {1'b0, opb_q[SEE_WORD_W-1:1]};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= A_DONE;
					end
				end
				A_DIV: begin
					// carry out set: no borrow, divisor fits
					acc_q <= sum[SEE_WORD_W] ? sum[SEE_WORD_W-1:0] : rem_sh;
					opa_q <= {opa_q[SEE_WORD_W-2:0], sum[SEE_WORD_W]};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= A_FIX;
					end
				end
				A_FIX: begin
					acc_q   <= neg_q ? sum[SEE_WORD_W-1:0] : add_y;
					state_q <= A_DONE;
				end
				A_DONE: begin
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign done   = (state_q == A_DONE);
	assign result = acc_q;

endmodule
`default_nettype wire

/* design/stack_expression_evaluator.sv */
`timescale 1ns / 1ps
`default_nettype none
// The last character of an expression leads through S_TOP (and S_TOP_RD when the top
// is read from the stack) before the result transaction is presented.
// Multiply and divide time is set by the shared ALU, one bit per cycle over 32 bits.
// arst_n clears the stack pointer, the sticky error, the mode and the output valid;
// stack contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
// stack_expression_evaluator: postfix/prefix stack expression evaluator
// Sequencer over a stack RAM and one iterative ALU; one result per expression.
// ----------------------------------------------------------------------------
module stack_expression_evaluator import see_pkg::*; #(
	parameter int STACK_DEPTH = SEE_STACK_DEPTH
) (
	input wire logic   clk,
	input wire logic   arst_n,
	see_cfg_if.sink    cfg,
	see_sym_if.sink    symbols,
	see_res_if.source  results
);

	localparam int SP_W  = $clog2(STACK_DEPTH + 1);  // pointer can equal depth
	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int EXT_W = (SP_W > SEE_DEPTH_W) ? SP_W : SEE_DEPTH_W;

	typedef enum logic [2:0] {
		S_IDLE,     // waiting for a symbol transaction
		S_DECODE,   // classify symbol; push digit or start operand fetch
		S_FETCH_A,  // first pop arrives from RAM
		S_FETCH_B,  // second pop arrives; start ALU
		S_EXEC,     // wait for ALU, write result back
		S_TOP,      // end of expression: decide status
		S_TOP_RD    // top of stack arrives from RAM
	} state_t;

	state_t                state_q;
	logic [SEE_SYM_W-1:0]  sym_q;
	logic                  last_q;
	logic                  mode_q;
	logic [SP_W-1:0]       sp_q;
	status_t               err_q;
	logic [SEE_WORD_W-1:0] first_q;

	logic                    out_valid_q;
	logic [SEE_WORD_W-1:0]   out_value_q;
	status_t                 out_status_q;
	logic [SEE_DEPTH_W-1:0]  out_depth_q;

	logic [SP_W-1:0]       sp_m1, sp_m2;
	logic                  sym_digit, sym_oper, stack_full, too_few;
	alu_op_t               cur_op;
	logic [SEE_WORD_W-1:0] lhs, rhs;
	logic                  div_zero;
	logic                  out_free;
	logic                  out_load;
	logic [EXT_W-1:0]      depth_ext;
	state_t                after_item;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [SEE_WORD_W-1:0] ram_wdata, ram_rdata;

	alu_req_t              alu_req;
	logic                  alu_done;
	logic [SEE_WORD_W-1:0] alu_res;

	// -------------------------------------------------------------------------
	// Decode helpers
	// -------------------------------------------------------------------------
	assign sp_m1      = sp_q - 1'b1;
	assign sp_m2      = sp_q - SP_W'(2);
	assign sym_digit  = is_digit(sym_q);
	assign sym_oper   = is_oper(sym_q);
	assign stack_full = (sp_q >= SP_W'(STACK_DEPTH));
	assign too_few    = (sp_q < SP_W'(2));
	assign cur_op     = op_of(sym_q);
	assign after_item = last_q ? S_TOP : S_IDLE;
	assign depth_ext  = EXT_W'(sp_q);

	// Postfix: first pop is the right operand. Prefix: first pop is the left.
	assign lhs      = mode_q ? first_q : ram_rdata;
	assign rhs      = mode_q ? ram_rdata : first_q;
	assign div_zero = ((cur_op == ALU_DIV) || (cur_op == ALU_REM)) && (rhs == '0);

	// Output register frees up this cycle if empty or being taken.
	assign out_free = !out_valid_q || results.ready;

	// A new result transaction is loaded this cycle.
	assign out_load = out_free && (((state_q == S_TOP) && ((err_q != ST_OK) || (sp_q == '0)))
		|| (state_q == S_TOP_RD));

	// -------------------------------------------------------------------------
	// Stack RAM port control
	// -------------------------------------------------------------------------
	assign ram_we = ((state_q == S_DECODE) && (err_q == ST_OK) && sym_digit && !stack_full)
		|| ((state_q == S_EXEC) && alu_done);
	assign ram_waddr = (state_q == S_EXEC) ? sp_m2[AW-1:0] : sp_q[AW-1:0];
	assign ram_wdata = (state_q == S_EXEC) ? alu_res : SEE_WORD_W'(sym_q - CH_ZERO);
	assign ram_raddr = (state_q == S_FETCH_A) ? sp_m2[AW-1:0] : sp_m1[AW-1:0];

	see_ram #(
		.WIDTH (SEE_WORD_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// -------------------------------------------------------------------------
	// Shared ALU, started once both operands are in hand
	// -------------------------------------------------------------------------
	assign alu_req.start = (state_q == S_FETCH_B) && !div_zero;
	assign alu_req.op    = cur_op;

	see_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.lhs    (lhs),
		.rhs    (rhs),
		.done   (alu_done),
		.result (alu_res)
	);

	// -------------------------------------------------------------------------
	// Sequencer
	// -------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sym_q        <= '0;
			last_q       <= 1'b0;
			mode_q       <= 1'b0;
			sp_q         <= '0;
			err_q        <= ST_OK;
			first_q      <= '0;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= ST_OK;
			out_depth_q  <= '0;
		end else begin
			if (cfg.valid) begin
				mode_q <= cfg.notation_mode;
			end

			// result transaction taken and nothing new loaded behind it
			if (results.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (symbols.valid) begin
						sym_q   <= symbols.symbol;
						last_q  <= symbols.last_symbol;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (err_q != ST_OK) begin
						// sticky error: stack frozen until end of expression
						state_q <= after_item;
					end else if (sym_digit) begin
						if (stack_full) begin
							err_q <= ST_OVER;
						end else begin
							sp_q <= sp_q + 1'b1;
						end
						state_q <= after_item;
					end else if (!sym_oper) begin
						err_q   <= ST_BAD;
						state_q <= after_item;
					end else if (too_few) begin
						err_q   <= ST_UNDER;
						state_q <= after_item;
					end else begin
						state_q <= S_FETCH_A;
					end
				end
				S_FETCH_A: begin
					first_q <= ram_rdata;
					state_q <= S_FETCH_B;
				end
				S_FETCH_B: begin
					if (div_zero) begin
						err_q   <= ST_DIVZ;
						state_q <= after_item;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (alu_done) begin
						// two popped, one pushed
						sp_q    <= sp_m1;
						state_q <= after_item;
					end
				end
				S_TOP: begin
					if ((err_q != ST_OK) || (sp_q == '0)) begin
						if (out_free) begin
							out_valid_q  <= 1'b1;
							out_value_q  <= '0;
							out_status_q <= (err_q != ST_OK) ? err_q : ST_EMPTY;
							out_depth_q  <= depth_ext[SEE_DEPTH_W-1:0];
							sp_q         <= '0;
							err_q        <= ST_OK;
							state_q      <= S_IDLE;
						end
					end else begin
						state_q <= S_TOP_RD;
					end
				end
				S_TOP_RD: begin
					// read address held at sp-1, so the RAM output stays put
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_value_q  <= ram_rdata;
						out_status_q <= ST_OK;
						out_depth_q  <= depth_ext[SEE_DEPTH_W-1:0];
						sp_q         <= '0;
						err_q        <= ST_OK;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// -------------------------------------------------------------------------
	// Ports
	// -------------------------------------------------------------------------
	assign cfg.ready              = 1'b1;
	assign symbols.ready          = (state_q == S_IDLE);
	assign results.valid          = out_valid_q;
	assign results.value          = out_value_q;
	assign results.status         = out_status_q;
	assign results.leftover_depth = out_depth_q;

	// -------------------------------------------------------------------------
	// Assertions
	// -------------------------------------------------------------------------
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_err_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK) && (state_q != S_TOP) |=> sp_q == $past(sp_q))
		else $error("stack moved under sticky error");

	a_alu_owner: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> state_q == S_EXEC)
		else $error("ALU finished outside execute state");

	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.status != ST_OK) |-> results.value == '0)
		else $error("nonzero value with error status");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !results.ready |=> out_value_q == $past(out_value_q))
		else $error("pending result overwritten");

endmodule
`default_nettype wire

/* dv/stack_expression_evaluator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_expression_evaluator_test: self-checking bench for the RPN evaluator
// Feeds postfix and reversed-prefix expressions through the symbol channel,
// tracks the evaluation in a shadow stack and checks every result
// transaction against it. Random idling on both sides, mode changes between
// phases.
// ----------------------------------------------------------------------------
module stack_expression_evaluator_test;
	import see_pkg::*;

	localparam int STACK_DEPTH   = SEE_STACK_DEPTH;
	localparam int SETTLE_CYCLES = 48;	// longest op (div/rem) plus result overhead
	localparam int RANDOM_SYMS   = 60;	// random symbols per phase
	localparam int FINAL_SYMS    = 40;	// closing segment, no idling
	localparam int MAX_REPORTS   = 10;

	typedef logic [SEE_SYM_W-1:0] sym_q_t[$];

	typedef struct packed {
		logic [SEE_SYM_W-1:0] symbol;
		logic                 last_symbol;
	} feed_item_t;

	typedef struct {
		logic signed [SEE_WORD_W-1:0] value;
		status_t                      status;
		logic [SEE_DEPTH_W-1:0]       leftover_depth;
	} answer_t;

	logic clk;
	logic arst_n;

	see_cfg_if cfg_ch ();
	see_sym_if sym_ch ();
	see_res_if res_ch ();

	stack_expression_evaluator #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.symbols (sym_ch),
		.results (res_ch)
	);

	// ------------------------------------------------------------------
	// Shared bench state
	// ------------------------------------------------------------------
	feed_item_t symbol_feed[$];	// symbols waiting to be driven
	answer_t    answer_q[$];	// evaluations still owed by the block

	// shadow copy of the evaluator
	logic [SEE_WORD_W-1:0] shadow_stack[STACK_DEPTH];
	int unsigned           shadow_depth = 0;
	status_t               shadow_error = ST_OK;
	logic                  shadow_mode  = 1'b0;

	int  symbols_queued     = 0;
	int  symbols_accepted   = 0;
	int  expressions_queued = 0;
	int  results_checked    = 0;
	int  mode_writes        = 0;
	int  mismatch_count     = 0;
	int  status_tally[8]    = '{default: 0};

	// idling controls
	bit  idling_on       = 1'b1;
	int  feed_gap        = 0;
	int  feed_gap_pct    = 20;
	int  drain_stall     = 0;
	int  drain_stall_pct = 20;
	logic sym_fire       = 1'b0;	// symbol transaction at the last rising edge
	feed_item_t next_item;

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin : clock_gen
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin : watchdog
		#6ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic void note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("[%0t] ERROR: %s", $time, msg);
	endfunction

	// ------------------------------------------------------------------
	// Shadow evaluator: one accepted symbol. Postfix takes the first pop as
	// the right operand, prefix (fed from the right end) as the left.
	// ------------------------------------------------------------------
	task automatic apply_symbol(input logic [SEE_SYM_W-1:0] sym, input logic last);
		logic [SEE_WORD_W-1:0] first_pop, second_pop, lhs, rhs, res;
		longint dividend, divisor, quotient;
		answer_t ans;
		// once an error is latched, everything up to the last symbol is dropped
		if (shadow_error == ST_OK) begin
			if (sym >= CH_ZERO && sym <= CH_NINE) begin
				// push would exceed the stack -> overflow
				if (shadow_depth >= STACK_DEPTH) begin
					shadow_error = ST_OVER;
				end else begin
					shadow_stack[shadow_depth] = SEE_WORD_W'(sym - CH_ZERO);
					shadow_depth++;
				end
			end else if (sym != CH_PLUS && sym != CH_MINUS && sym != CH_MUL &&
				sym != CH_DIV && sym != CH_MOD) begin
				shadow_error = ST_BAD;
			end else if (shadow_depth < 2) begin
				shadow_error = ST_UNDER;
			end else begin
				first_pop  = shadow_stack[shadow_depth-1];
				second_pop = shadow_stack[shadow_depth-2];
				lhs = shadow_mode ? first_pop : second_pop;
				rhs = shadow_mode ? second_pop : first_pop;
				if ((sym == CH_DIV || sym == CH_MOD) && rhs == '0) begin
					shadow_error = ST_DIVZ;
				end else begin
					case (sym)
						CH_PLUS:  res = lhs + rhs;
						CH_MINUS: res = lhs - rhs;
						CH_MUL:   res = lhs * rhs;
						default: begin
							// 64-bit math keeps MIN / -1 well defined; truncates toward zero
							dividend = $signed(lhs);
							divisor  = $signed(rhs);
							quotient = (sym == CH_DIV) ? dividend / divisor
								: dividend % divisor;
							res = quotient[SEE_WORD_W-1:0];
						end
					endcase
					shadow_stack[shadow_depth-2] = res;
					shadow_depth--;
				end
			end
		end
		if (last) begin
			ans.value          = '0;
			ans.status         = shadow_error;
			ans.leftover_depth = SEE_DEPTH_W'(shadow_depth);
			if (shadow_error == ST_OK) begin
				if (shadow_depth == 0 || shadow_depth > STACK_DEPTH)
					ans.status = ST_EMPTY;
				else
					ans.value = shadow_stack[shadow_depth-1];
			end
			answer_q.push_back(ans);
			shadow_depth = 0;
			shadow_error = ST_OK;
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: sample all channels at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		answer_t want;
		sym_fire <= sym_ch.valid && sym_ch.ready;
		if (cfg_ch.valid && cfg_ch.ready) begin
			shadow_mode = cfg_ch.notation_mode;
			mode_writes++;
		end
		if (sym_ch.valid && sym_ch.ready) begin
			symbols_accepted++;
			apply_symbol(sym_ch.symbol, sym_ch.last_symbol);
		end
		if (res_ch.valid && res_ch.ready) begin
			results_checked++;
			status_tally[res_ch.status]++;
			if (answer_q.size() == 0) begin
				note_failure($sformatf("unexpected result: value %0d status %0d depth %0d",
					res_ch.value, res_ch.status, res_ch.leftover_depth));
			end else begin
				want = answer_q.pop_front();
				if (res_ch.value !== want.value || res_ch.status !== want.status ||
					res_ch.leftover_depth !== want.leftover_depth) begin
					note_failure($sformatf({"result mismatch: expected value %0d status %0d",
						" depth %0d, got value %0d status %0d depth %0d"},
						want.value, want.status, want.leftover_depth,
						res_ch.value, res_ch.status, res_ch.leftover_depth));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Symbol driver: holds each transaction until accepted, inserts idle
	// bursts between transactions while idling is on.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : symbol_driver
		if (!arst_n) begin
			sym_ch.valid <= 1'b0;
		end else if (!sym_ch.valid || sym_fire) begin
			if (feed_gap > 0) begin
				sym_ch.valid <= 1'b0;
				feed_gap     <= feed_gap - 1;
			end else if (symbol_feed.size() == 0) begin
				sym_ch.valid <= 1'b0;
			end else if (idling_on && $urandom_range(0, 99) < feed_gap_pct) begin
				sym_ch.valid <= 1'b0;
				feed_gap     <= $urandom_range(0, 10);
			end else begin
				next_item = symbol_feed.pop_front();
				sym_ch.valid       <= 1'b1;
				sym_ch.symbol      <= next_item.symbol;
				sym_ch.last_symbol <= next_item.last_symbol;
				// now and then change the idle density, zero included
				if ($urandom_range(0, 63) == 0)
					feed_gap_pct <= $urandom_range(0, 2) * 20;
			end
		end
	end

	// result side back-pressure, same burst shape
	always @(negedge clk) begin : result_drain
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (drain_stall > 0) begin
			res_ch.ready <= 1'b0;
			drain_stall  <= drain_stall - 1;
		end else if (idling_on && $urandom_range(0, 99) < drain_stall_pct) begin
			res_ch.ready <= 1'b0;
			drain_stall  <= $urandom_range(0, 10);
		end else begin
			res_ch.ready <= 1'b1;
			if ($urandom_range(0, 31) == 0)
				drain_stall_pct <= $urandom_range(0, 2) * 25;
		end
	end

	// ------------------------------------------------------------------
	// Expression builders
	// ------------------------------------------------------------------
	function automatic sym_q_t one_symbol(input logic [SEE_SYM_W-1:0] sym);
		sym_q_t s;
		s.push_back(sym);
		return s;
	endfunction

	function automatic sym_q_t digit_seq(input int d);
		return one_symbol(CH_ZERO + SEE_SYM_W'(d));
	endfunction

	function automatic logic [SEE_SYM_W-1:0] random_digit();
		return CH_ZERO + SEE_SYM_W'($urandom_range(0, 9));
	endfunction

	// multiply is weighted up so values reach the wrap range
	function automatic logic [SEE_SYM_W-1:0] random_op();
		logic [SEE_SYM_W-1:0] ops[6];
		ops = '{CH_PLUS, CH_MINUS, CH_MUL, CH_MUL, CH_DIV, CH_MOD};
		return ops[$urandom_range(0, 5)];
	endfunction

	// lhs op rhs in the order the current notation expects on the wire
	function automatic sym_q_t binary_expr(input logic mode, input sym_q_t lhs,
		input sym_q_t rhs, input logic [SEE_SYM_W-1:0] op);
		sym_q_t s;
		if (mode) begin
			foreach (rhs[i]) s.push_back(rhs[i]);
			foreach (lhs[i]) s.push_back(lhs[i]);
		end else begin
			foreach (lhs[i]) s.push_back(lhs[i]);
			foreach (rhs[i]) s.push_back(rhs[i]);
		end
		s.push_back(op);
		return s;
	endfunction

	// 2 * 8^10 wraps to the most negative word; products commute so any mode works
	function automatic sym_q_t min_word();
		sym_q_t s;
		s = digit_seq(2);
		repeat (10) begin
			s.push_back(CH_ZERO + 8'd8);
			s.push_back(CH_MUL);
		end
		return s;
	endfunction

	// balanced RPN shape: valid in both notations since the stream is just
	// a reversed tree in prefix mode
	function automatic sym_q_t well_formed(input int max_digits);
		sym_q_t s;
		int digits, pushed, depth;
		digits = $urandom_range(1, max_digits);
		pushed = 0;
		depth  = 0;
		while (pushed < digits || depth > 1) begin
			if (pushed < digits && (depth < 2 || $urandom_range(0, 1))) begin
				s.push_back(random_digit());
				pushed++;
				depth++;
			end else begin
				s.push_back(random_op());
				depth--;
			end
		end
		return s;
	endfunction

	function automatic sym_q_t random_expression();
		sym_q_t s;
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			s = well_formed(($urandom_range(0, 9) == 0) ? 30 : 8);
		end else if (kind < 75) begin
			// broken: damage a well-formed expression
			s = well_formed(8);
			case ($urandom_range(0, 3))
				0: if (s.size() > 1) s.delete($urandom_range(0, s.size() - 1));
				1: s.insert($urandom_range(0, s.size()), random_op());
				2: repeat ($urandom_range(1, 3)) s.push_back(random_digit());
				default: s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
			endcase
		end else if (kind < 87) begin
			// raw bytes, full 8-bit range
			repeat ($urandom_range(1, 5)) s.push_back(8'($urandom_range(0, 255)));
		end else begin
			// digits and operators in no particular order
			repeat ($urandom_range(1, 10))
				s.push_back(($urandom_range(0, 2) == 0) ? random_op() : random_digit());
		end
		return s;
	endfunction

	task automatic queue_expression(input sym_q_t s);
		feed_item_t item;
		foreach (s[i]) begin
			item.symbol      = s[i];
			item.last_symbol = (i == s.size() - 1);
			symbol_feed.push_back(item);
			symbols_queued++;
		end
		expressions_queued++;
	endtask

	task automatic queue_random(input int count);
		int target;
		target = symbols_queued + count;
		while (symbols_queued < target)
			queue_expression(random_expression());
	endtask

	// wrap-around arithmetic corners, optionally the stack depth limit too
	task automatic queue_corners(input logic mode, input bit with_deep);
		sym_q_t neg_one, s;
		neg_one = binary_expr(mode, digit_seq(0), digit_seq(1), CH_MINUS);
		queue_expression(min_word());
		queue_expression(binary_expr(mode, min_word(), neg_one, CH_DIV));
		queue_expression(binary_expr(mode, min_word(), neg_one, CH_MOD));
		queue_expression(binary_expr(mode, min_word(), digit_seq(1), CH_MINUS));
		if (with_deep) begin
			// exactly full: leftover depth reaches the stack size
			s.delete();
			repeat (STACK_DEPTH) s.push_back(random_digit());
			queue_expression(s);
			// one push too many, then an operator that must be ignored
			s.push_back(random_digit());
			s.push_back(random_op());
			queue_expression(s);
		end
	endtask

	task automatic write_notation(input logic mode);
		@(negedge clk);
		cfg_ch.valid         <= 1'b1;
		cfg_ch.notation_mode <= mode;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// wait for every symbol to go in and every result to come out, then
	// give the block time to finish any trailing operation
	task automatic settle();
		while (symbol_feed.size() != 0 || symbols_accepted != symbols_queued ||
			answer_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Stimulus sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic   mode_now;
		sym_q_t s;
		arst_n               = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.notation_mode = 1'b0;
		sym_ch.valid         = 1'b0;
		sym_ch.symbol        = '0;
		sym_ch.last_symbol   = 1'b0;
		res_ch.ready         = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// phase 0: postfix from reset, no register write yet
		mode_now = 1'b0;
		queue_expression(binary_expr(mode_now, digit_seq(7), digit_seq(2), CH_PLUS));
		queue_expression(binary_expr(mode_now, digit_seq(2), digit_seq(7), CH_MINUS));
		queue_expression(binary_expr(mode_now, digit_seq(9), digit_seq(8), CH_MUL));
		// negative operands truncate toward zero
		queue_expression(binary_expr(mode_now,
			binary_expr(mode_now, digit_seq(0), digit_seq(7), CH_MINUS), digit_seq(2), CH_DIV));
		queue_expression(binary_expr(mode_now,
			binary_expr(mode_now, digit_seq(0), digit_seq(7), CH_MINUS), digit_seq(2), CH_MOD));
		queue_expression(binary_expr(mode_now, digit_seq(5), digit_seq(0), CH_DIV));
		queue_expression(binary_expr(mode_now, digit_seq(5), digit_seq(0), CH_MOD));
		queue_expression(one_symbol(CH_PLUS));	// too few operands
		queue_expression(one_symbol(8'h00));	// unknown char on the last symbol
		s = one_symbol(8'hFF);			// unknown char stays latched
		s.push_back(CH_ZERO + 8'd1);
		queue_expression(s);
		s = digit_seq(1);			// two values left behind
		s.push_back(CH_NINE);
		queue_expression(s);
		queue_corners(mode_now, 1'b1);
		queue_random(RANDOM_SYMS);
		settle();

		// phases 1..3 alternate notation: prefix, postfix, prefix
		for (int phase = 1; phase < 4; phase++) begin
			mode_now = ~mode_now;
			write_notation(mode_now);
			queue_corners(mode_now, phase == 1);
			queue_random(RANDOM_SYMS);
			settle();
		end

		// closing segment back in postfix with both sides running flat out
		idling_on = 1'b0;
		mode_now  = 1'b0;
		write_notation(mode_now);
		queue_random(FINAL_SYMS);
		settle();

		if (answer_q.size() != 0)
			note_failure($sformatf("%0d results never arrived", answer_q.size()));

		$display("Covered %0d symbols in %0d expressions, %0d mode writes, %0d results",
			symbols_accepted, expressions_queued, mode_writes, results_checked);
		$display("Status mix: ok %0d, underflow %0d, overflow %0d, div0 %0d, bad char %0d",
			status_tally[ST_OK], status_tally[ST_UNDER], status_tally[ST_OVER],
			status_tally[ST_DIVZ], status_tally[ST_BAD]);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
design/see_pkg.sv
design/see_if.sv
design/see_ram.sv
design/see_alu.sv
design/stack_expression_evaluator.sv
dv/stack_expression_evaluator_test.sv
